/* hdl/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PriW   = 8;
  localparam int unsigned OccW   = 5;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PriW-1:0]          pri;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t fresh;
  } ctrl_t;

endpackage

/* hdl/sorted_priority_queue_top.sv */
// channel | handshake          | payload
// request | in_valid, in_stall | opcode, in_value, in_priority
// result  | out_valid, out_stall | status, out_value, out_priority, occupancy
//
// each request completes at the edge that takes it: every cell compares its priority with the
// incoming one at once and shifts right (insert) or left (pop) in the same edge
// a new request is taken in every cycle while the result register is free or drained
// rst clears the fill count and result valid; cell contents need no reset
// a stalled result holds, and in_stall is raised only while it waits
module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  opcode,
  input  logic signed [31:0] in_value,
  input  logic [7:0]  in_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic signed [31:0] out_value,
  output logic [7:0]  out_priority,
  output logic [4:0]  occupancy
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            accept;
  logic            full;
  logic            empty;
  ctrl_t           ctrl;
  entry_t          cell_data [CAPACITY];
  logic            cell_gt   [CAPACITY];
  logic            cell_occ  [CAPACITY];

  // result register parts the two sides; wait only when it holds an untaken result
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count == CntW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    ctrl.enq         = accept && (opcode == OP_ENQ) && !full;
    ctrl.deq         = accept && (opcode == OP_DEQ) && !empty;
    ctrl.fresh.value = in_value;
    ctrl.fresh.pri   = in_priority;
  end

  // fill count
  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + 1'b1;
    end else if (ctrl.deq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // chain of cells, cell 0 is the front of the queue
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_data;
    entry_t right_data;
    logic   left_gt;

    assign cell_occ[i] = (CntW'(i) < count);

    if (i == 0) begin : g_front
      assign left_gt   = 1'b0;
      assign left_data = ctrl.fresh;
    end else begin : g_mid
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_rear
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (cell_occ[i]),
      .left_gt    (left_gt),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .gt         (cell_gt[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy    <= 5'(count_next);
      out_value    <= '0;
      out_priority <= '0;
      case (opcode)
        OP_ENQ: begin
          status <= full ? ST_FULL : ST_ENQUEUED;
        end
        OP_DEQ: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            status       <= ST_DEQUEUED;
            out_value    <= cell_data[0].value;
            out_priority <= cell_data[0].pri;
          end
        end
        default: begin
          status <= ST_EMPTY;
        end
      endcase
    end
  end

endmodule

/* hdl/spq_cell.sv */
module spq_cell (
  input  logic           clk,
  input  spq_pkg::ctrl_t ctrl,
  input  logic           occ,
  input  logic           left_gt,
  input  spq_pkg::entry_t left_data,
  input  spq_pkg::entry_t right_data,
  output spq_pkg::entry_t data,
  output logic           gt
);
  import spq_pkg::*;

  // empty slot or strictly larger priority number: new entry lands here or earlier
  assign gt = !occ || (data.pri > ctrl.fresh.pri);

  always_ff @(posedge clk) begin
    if (ctrl.enq && gt) begin
      data <= left_gt ? left_data : ctrl.fresh;
    end else if (ctrl.deq) begin
      data <= right_data;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned PhaseItems = 115;
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned MaxReports = 10;

  // one result as the queue should report it
  typedef struct {
    status_t                  st;
    logic signed [ValueW-1:0] value;
    logic [PriW-1:0]          pri;
    logic [OccW-1:0]          occ;
  } queue_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [0:0]               opcode = OP_ENQ;
  logic signed [ValueW-1:0] in_value = '0;
  logic [PriW-1:0]          in_priority = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [ValueW-1:0] out_value;
  logic [PriW-1:0]          out_priority;
  logic [OccW-1:0]          occupancy;

  // shadow copy of the sorted store, front entry at index zero
  logic signed [ValueW-1:0] held_value [Capacity];
  logic [PriW-1:0]          held_pri   [Capacity];
  int unsigned              held_count = 0;

  queue_result_t            pending_results [$];
  int unsigned              mismatch_count = 0;

  // idling knobs, percent of cycles
  int unsigned              send_idle_pct = 0;
  int unsigned              stall_pct = 0;

  // long receiver hold-off, armed by a test and counted down by the stall process
  bit                       hold_go = 1'b0;
  int unsigned              hold_left = 0;

  sorted_priority_queue_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .in_value     (in_value),
    .in_priority  (in_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_value    (out_value),
    .out_priority (out_priority),
    .occupancy    (occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one request to the shadow store and return what the queue must answer
  function automatic queue_result_t apply_request(opcode_t op, logic signed [ValueW-1:0] v,
                                                  logic [PriW-1:0] p);
    queue_result_t r;
    int unsigned   pos;
    r.value = '0;
    r.pri   = '0;
    if (op == OP_ENQ) begin
      if (held_count >= Capacity) begin
        r.st = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or lower number
        pos = 0;
        while (pos < held_count && held_pri[pos] <= p) pos++;
        for (int unsigned k = held_count; k > pos; k--) begin
          held_value[k] = held_value[k-1];
          held_pri[k]   = held_pri[k-1];
        end
        held_value[pos] = v;
        held_pri[pos]   = p;
        held_count++;
        r.st = ST_ENQUEUED;
      end
    end else begin
      if (held_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.st    = ST_DEQUEUED;
        r.value = held_value[0];
        r.pri   = held_pri[0];
        for (int unsigned k = 1; k < held_count; k++) begin
          held_value[k-1] = held_value[k];
          held_pri[k-1]   = held_pri[k];
        end
        held_count--;
      end
    end
    r.occ = OccW'(held_count);
    return r;
  endfunction

  // one process sees both channels: accepted requests are predicted first,
  // so a result in the same edge always finds its expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_results.push_back(apply_request(opcode_t'(opcode), in_value, in_priority));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("tb: result with no request waiting at %0t: status %0d value %0d",
                     $realtime, status, out_value);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st || out_value !== want.value ||
              out_priority !== want.pri || occupancy !== want.occ) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display(
                "tb: mismatch %0t st %0d/%0d value %0d/%0d pri %0d/%0d occ %0d/%0d (exp/act)",
                $realtime, want.st, status, want.value, out_value,
                want.pri, out_priority, want.occ, occupancy);
          end
        end
      end
    end
  end

  // receiver: random stalls, or a solid hold-off while one is armed
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = HoldCycles;
      hold_go   = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one request and return at the edge that takes it
  // valid is only lowered in idle cycles, so back-to-back requests keep it high
  task automatic send_request(opcode_t op, logic signed [ValueW-1:0] v, logic [PriW-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      // junk on the payload while idle must not matter
      opcode      <= 1'($urandom);
      in_value    <= $urandom;
      in_priority <= PriW'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    in_value    <= v;
    in_priority <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // priorities lean on a few small numbers so that ties are common
  task automatic send_random_request(int unsigned enq_pct);
    opcode_t                  op;
    logic [PriW-1:0]          p;
    logic signed [ValueW-1:0] v;
    op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
    case ($urandom_range(9))
      0:       p = '0;
      1:       p = '1;
      2, 3, 4: p = PriW'($urandom_range(3));
      default: p = PriW'($urandom);
    endcase
    case ($urandom_range(19))
      0:       v = 32'sh7fffffff;
      1:       v = 32'sh80000000;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    send_request(op, v, p);
  endtask

  // dequeue from a queue that was never filled
  task automatic test_empty_queue();
    send_request(OP_DEQ, 32'sh5a5a5a5a, 8'hff);
    send_request(OP_DEQ, 32'sh7fffffff, 8'h00);
  endtask

  // value and priority extremes, and two equal priorities that must keep arrival order
  task automatic test_extremes_and_ties();
    send_request(OP_ENQ, 32'sh7fffffff, 8'hff);
    send_request(OP_ENQ, 32'sh80000000, 8'h00);
    send_request(OP_ENQ, -32'sd1,       8'h80);
    send_request(OP_ENQ, 32'sd0,        8'h80);
    repeat (4) send_request(OP_DEQ, '0, '0);
  endtask

  // fill with falling priorities so each entry lands at the front, then overflow
  task automatic test_full_queue();
    for (int unsigned i = 0; i < Capacity; i++)
      send_request(OP_ENQ, $urandom, PriW'(250 - 15 * i));
    send_request(OP_ENQ, 32'sh12345678, 8'h00);
  endtask

  // receiver holds off while requests keep coming, so the input must stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b1;
    repeat (24) send_random_request(40);
    // sender pauses here until the queue has answered everything
    wait_drained();
  endtask

  // bursts that lean toward filling, churning or draining the queue
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_in);
    int unsigned sent;
    int unsigned burst;
    int unsigned enq_pct;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in;
    sent          = 0;
    while (sent < PhaseItems) begin
      burst = $urandom_range(30, 6);
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 20;
      endcase
      repeat (burst) send_random_request(enq_pct);
      sent += burst;
      if ($urandom_range(4) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_extremes_and_ties();
    test_full_queue();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(78, 0);
    test_random_traffic(0, 78);
    test_random_traffic(37, 37);

    wait_drained();
    // keep the clock running to catch any stray result
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
